// File: src/aps_pkg.sv
package aps_pkg;

  // Front stages: cross products, squares, sums, threshold, wide products
  localparam int FRONT_STAGES = 9;
  // Quotient bits of floor(2^30 * P * T / (A * B)), quotient is at most 2^30
  localparam int DIV_BITS = 31;
  // Digit steps of the integer square root of the quotient
  localparam int SQRT_STEPS = 16;
  // Pipeline depth: front stages, divider and square root, output register included
  localparam int LATENCY = FRONT_STAGES + DIV_BITS + SQRT_STEPS + 1;
  // Stage that first knows the sign and the degenerate flag
  localparam int SIDE_FIRST = 5;
  localparam int SIDE_LEN = LATENCY - SIDE_FIRST;

  // Register indexes of the configuration port
  localparam logic REG_MIN_NORMAL_SQ = 1'b0;

  // Flags that travel with an item once the threshold check is done
  typedef struct packed {
    logic neg;
    logic degen;
  } side_t;

endpackage

// File: src/azimuthal_plane_angle_sine.sv
// Signed sine of the angle between the planes (photon, beam) and (photon,
// hadron). One item enters per cycle, and the pipeline holds as a whole
// while a result waits on out_stall. The depth is set by a 31-stage
// restoring divider (one quotient bit per stage) and a 16-stage square root
// (one root bit per stage) behind nine stages of cross products and split
// 32x32 and 24x24 multiplies. min_normal_sq sits at byte address 0 (reset
// 1); the result is zero with degenerate set when either squared normal
// length is not above it.
module azimuthal_plane_angle_sine (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_beam_x,
  input  logic signed [15:0] in_beam_y,
  input  logic signed [15:0] in_beam_z,
  input  logic signed [15:0] in_photon_x,
  input  logic signed [15:0] in_photon_y,
  input  logic signed [15:0] in_photon_z,
  input  logic signed [15:0] in_hadron_x,
  input  logic signed [15:0] in_hadron_y,
  input  logic signed [15:0] in_hadron_z,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sin_phi,
  output logic               out_degenerate,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int LAT = aps_pkg::LATENCY;
  localparam int DB  = aps_pkg::DIV_BITS;
  localparam int SQ  = aps_pkg::SQRT_STEPS;
  localparam int SL  = aps_pkg::SIDE_LEN;

  logic               en;
  logic [LAT-1:0]     vld_r;
  logic [31:0]        th_r;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == aps_pkg::REG_MIN_NORMAL_SQ) ? th_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      th_r <= 32'd1;
    end else if (psel && penable && pwrite &&
                 paddr[2] == aps_pkg::REG_MIN_NORMAL_SQ) begin
      th_r <= pwdata;
    end
  end

  // hold the whole pipeline while a result waits
  assign in_stall  = vld_r[LAT-1] && out_stall;
  assign en        = !in_stall;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  logic signed [15:0] bv [3];
  logic signed [15:0] pv [3];
  logic signed [15:0] hv [3];

  assign bv[0] = in_beam_x;
  assign bv[1] = in_beam_y;
  assign bv[2] = in_beam_z;
  assign pv[0] = in_photon_x;
  assign pv[1] = in_photon_y;
  assign pv[2] = in_photon_z;
  assign hv[0] = in_hadron_x;
  assign hv[1] = in_hadron_y;
  assign hv[2] = in_hadron_z;

  logic signed [31:0] s1_n1a_r [3];
  logic signed [31:0] s1_n1b_r [3];
  logic signed [31:0] s1_n2a_r [3];
  logic signed [31:0] s1_n2b_r [3];
  logic signed [31:0] s1_bha_r [3];
  logic signed [31:0] s1_bhb_r [3];
  logic signed [31:0] s1_psq_r [3];
  logic signed [15:0] s1_p_r   [3];
  logic signed [32:0] s2_n1_r  [3];
  logic signed [32:0] s2_n2_r  [3];
  logic signed [32:0] s2_bh_r  [3];
  logic signed [15:0] s2_p_r   [3];
  logic signed [65:0] n1sq_c   [3];
  logic signed [65:0] n2sq_c   [3];
  logic signed [48:0] pbh_c    [3];
  logic [62:0]        s3_n1sq_r [3];
  logic [62:0]        s3_n2sq_r [3];
  logic signed [48:0] s3_pbh_r [3];

  // per-component stages: products, cross-product differences, squares
  for (genvar g = 0; g < 3; g++) begin : g_comp
    localparam int G1 = (g + 1) % 3;
    localparam int G2 = (g + 2) % 3;

    assign n1sq_c[g] = s2_n1_r[g] * s2_n1_r[g];
    assign n2sq_c[g] = s2_n2_r[g] * s2_n2_r[g];
    assign pbh_c[g]  = s2_p_r[g] * s2_bh_r[g];

    always_ff @(posedge clk) begin
      if (en) begin
        s1_n1a_r[g]  <= pv[G1] * bv[G2];
        s1_n1b_r[g]  <= pv[G2] * bv[G1];
        s1_n2a_r[g]  <= pv[G1] * hv[G2];
        s1_n2b_r[g]  <= pv[G2] * hv[G1];
        s1_bha_r[g]  <= bv[G1] * hv[G2];
        s1_bhb_r[g]  <= bv[G2] * hv[G1];
        s1_psq_r[g]  <= pv[g] * pv[g];
        s1_p_r[g]    <= pv[g];
        s2_n1_r[g]   <= 33'(s1_n1a_r[g]) - 33'(s1_n1b_r[g]);
        s2_n2_r[g]   <= 33'(s1_n2a_r[g]) - 33'(s1_n2b_r[g]);
        s2_bh_r[g]   <= 33'(s1_bha_r[g]) - 33'(s1_bhb_r[g]);
        s2_p_r[g]    <= s1_p_r[g];
        s3_n1sq_r[g] <= n1sq_c[g][62:0];
        s3_n2sq_r[g] <= n2sq_c[g][62:0];
        s3_pbh_r[g]  <= pbh_c[g];
      end
    end
  end

  logic [31:0]        s2_psum_r, s3_psum_r, s4_psum_r, s5_psum_r, s6_psum_r, s7_psum_r;
  logic [63:0]        s4_a_r, s4_b_r, s5_a_r, s5_b_r;
  logic signed [50:0] s4_t_r;
  logic signed [50:0] tabs_c;
  logic [47:0]        s5_tm_r;
  logic [63:0]        s6_abhh_r, s6_abhl_r, s6_ablh_r, s6_abll_r;
  logic [47:0]        s6_thh_r, s6_thl_r, s6_tll_r;
  logic [127:0]       s7_ab_r, s8_ab_r, s9_ab_r;
  logic [95:0]        s7_t_r;
  logic [63:0]        s8_pt0_r, s8_pt1_r, s8_pt2_r;
  logic [127:0]       s9_pt_r;
  aps_pkg::side_t     side_r [SL];

  assign tabs_c = s4_t_r[50] ? -s4_t_r : s4_t_r;

  // sums, threshold check, split wide products
  always_ff @(posedge clk) begin
    if (en) begin
      s2_psum_r <= 32'(s1_psq_r[0]) + 32'(s1_psq_r[1]) + 32'(s1_psq_r[2]);
      s3_psum_r <= s2_psum_r;
      s4_a_r    <= 64'(s3_n1sq_r[0]) + 64'(s3_n1sq_r[1]) + 64'(s3_n1sq_r[2]);
      s4_b_r    <= 64'(s3_n2sq_r[0]) + 64'(s3_n2sq_r[1]) + 64'(s3_n2sq_r[2]);
      s4_t_r    <= 51'(s3_pbh_r[0]) + 51'(s3_pbh_r[1]) + 51'(s3_pbh_r[2]);
      s4_psum_r <= s3_psum_r;
      side_r[0] <= '{neg: s4_t_r[50],
                     degen: !((s4_a_r > {32'd0, th_r}) && (s4_b_r > {32'd0, th_r}))};
      s5_tm_r   <= tabs_c[47:0];
      s5_a_r    <= s4_a_r;
      s5_b_r    <= s4_b_r;
      s5_psum_r <= s4_psum_r;
      s6_abhh_r <= s5_a_r[63:32] * s5_b_r[63:32];
      s6_abhl_r <= s5_a_r[63:32] * s5_b_r[31:0];
      s6_ablh_r <= s5_a_r[31:0] * s5_b_r[63:32];
      s6_abll_r <= s5_a_r[31:0] * s5_b_r[31:0];
      s6_thh_r  <= s5_tm_r[47:24] * s5_tm_r[47:24];
      s6_thl_r  <= s5_tm_r[47:24] * s5_tm_r[23:0];
      s6_tll_r  <= s5_tm_r[23:0] * s5_tm_r[23:0];
      s6_psum_r <= s5_psum_r;
      s7_ab_r   <= {s6_abhh_r, 64'd0}
                 + {31'd0, 65'(s6_abhl_r) + 65'(s6_ablh_r), 32'd0}
                 + {64'd0, s6_abll_r};
      s7_t_r    <= {s6_thh_r, 48'd0} + {23'd0, s6_thl_r, 25'd0} + {48'd0, s6_tll_r};
      s7_psum_r <= s6_psum_r;
      s8_pt0_r  <= s7_psum_r * s7_t_r[31:0];
      s8_pt1_r  <= s7_psum_r * s7_t_r[63:32];
      s8_pt2_r  <= s7_psum_r * s7_t_r[95:64];
      s8_ab_r   <= s7_ab_r;
      s9_pt_r   <= {s8_pt2_r, 64'd0} + {32'd0, s8_pt1_r, 32'd0} + {64'd0, s8_pt0_r};
      s9_ab_r   <= s8_ab_r;
      for (int k = 1; k < SL; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  logic [127:0]  div_rem_r [DB];
  logic [DB-1:0] div_q_r   [DB];
  logic [127:0]  div_ab_r  [DB-1];

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < DB; j++) begin : g_div
    logic [128:0]  cur;
    logic [128:0]  diff;
    logic [127:0]  ab_in;
    logic [DB-1:0] q_in;
    logic          ge;

    if (j == 0) begin : g_first
      assign cur   = {1'b0, s9_pt_r};
      assign ab_in = s9_ab_r;
      assign q_in  = '0;
    end else begin : g_next
      assign cur   = {div_rem_r[j-1], 1'b0};
      assign ab_in = div_ab_r[j-1];
      assign q_in  = div_q_r[j-1];
    end

    assign ge   = cur >= {1'b0, ab_in};
    assign diff = cur - {1'b0, ab_in};

    always_ff @(posedge clk) begin
      if (en) begin
        div_rem_r[j] <= ge ? diff[127:0] : cur[127:0];
        div_q_r[j]   <= {q_in[DB-2:0], ge};
      end
    end

    if (j < DB - 1) begin : g_ab
      always_ff @(posedge clk) begin
        if (en) begin
          div_ab_r[j] <= ab_in;
        end
      end
    end
  end

  logic [17:0]   sq_rem_r  [SQ];
  logic [15:0]   sq_root_r [SQ];
  logic [DB-1:0] sq_q_r    [SQ-1];

  // digit-by-digit square root, two radicand bits per stage
  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    localparam int K = SQ - 1 - j;
    logic [17:0]   rem_in;
    logic [15:0]   root_in;
    logic [DB-1:0] q_in;
    logic [31:0]   qpad;
    logic [19:0]   cur;
    logic [19:0]   trial;
    logic [19:0]   diff;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign q_in    = div_q_r[DB-1];
    end else begin : g_next
      assign rem_in  = sq_rem_r[j-1];
      assign root_in = sq_root_r[j-1];
      assign q_in    = sq_q_r[j-1];
    end

    assign qpad  = {1'b0, q_in};
    assign cur   = {rem_in, qpad[2*K+1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[j]  <= ge ? diff[17:0] : cur[17:0];
        sq_root_r[j] <= {root_in[14:0], ge};
      end
    end

    if (j < SQ - 1) begin : g_q
      always_ff @(posedge clk) begin
        if (en) begin
          sq_q_r[j] <= q_in;
        end
      end
    end
  end

  // round the root to the magnitude, apply sign, zero degenerate items
  logic [16:0]        mag_c;
  logic signed [15:0] sin_c;
  logic signed [15:0] out_sin_phi_r;
  logic               out_degenerate_r;

  assign mag_c = 17'(sq_root_r[SQ-1]) + 17'd1;

  always_comb begin
    if (side_r[SL-1].degen) begin
      sin_c = 16'sd0;
    end else if (side_r[SL-1].neg) begin
      sin_c = -$signed(mag_c[16:1]);
    end else begin
      sin_c = $signed(mag_c[16:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sin_phi_r    <= sin_c;
      out_degenerate_r <= side_r[SL-1].degen;
    end
  end

  assign out_sin_phi    = out_sin_phi_r;
  assign out_degenerate = out_degenerate_r;

endmodule

// File: src/aps_check.sv
module aps_check (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_sin_phi,
  input logic               out_degenerate
);

  // a degenerate result always carries a zero sine
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |-> (out_sin_phi == 16'sd0))
    else $error("degenerate result with nonzero sine");

  // the sine stays within plus and minus one in Q1.14
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sin_phi >= -16'sd16384 && out_sin_phi <= 16'sd16384))
    else $error("sine out of range");

  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_sin_phi) && $stable(out_degenerate)))
    else $error("held result changed");

  // reset drops all results
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind azimuthal_plane_angle_sine aps_check u_aps_check (.*);

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

  typedef logic signed [15:0] comp_t [9];  // beam xyz, photon xyz, hadron xyz

  typedef struct {
    logic signed [15:0] sin_phi;
    logic               degenerate;
  } sine_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] in_beam_x, in_beam_y, in_beam_z;
  logic signed [15:0] in_photon_x, in_photon_y, in_photon_z;
  logic signed [15:0] in_hadron_x, in_hadron_y, in_hadron_z;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_sin_phi;
  logic out_degenerate;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  sine_t sine_queue[$];
  logic [31:0] min_sq_shadow;
  int idle_pct;
  int stall_pct;
  int fail_count;

  azimuthal_plane_angle_sine uut (.*);

  always #1 clk = ~clk;

  // Randomize receiver stall each cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    sine_t exp_sine;
    if (rst_n && out_valid && !out_stall) begin
      if (sine_queue.size() == 0) begin
        $error("unexpected result: sin_phi %0d degenerate %0b", out_sin_phi, out_degenerate);
        fail_count++;
      end else begin
        exp_sine = sine_queue.pop_front();
        if (out_sin_phi !== exp_sine.sin_phi) begin
          $error("sin_phi: expected %0d actual %0d", exp_sine.sin_phi, out_sin_phi);
          fail_count++;
        end
        if (out_degenerate !== exp_sine.degenerate) begin
          $error("degenerate: expected %0b actual %0b", exp_sine.degenerate, out_degenerate);
          fail_count++;
        end
      end
    end
  end

  // Exact integer sine of the angle between the planes
  function automatic sine_t predict_sine(comp_t c, logic [31:0] thr);
    longint b[3], p[3], h[3], n1[3], n2[3], bh[3];
    longint t;
    bit [63:0] a_sq, b_sq, p_sq, mg;
    bit [191:0] ab, rhs, lhs, tm;
    int s, cand, bitw;
    sine_t r;
    for (int i = 0; i < 3; i++) begin
      b[i] = 64'(c[i]);
      p[i] = 64'(c[3 + i]);
      h[i] = 64'(c[6 + i]);
    end
    n1[0] = p[1] * b[2] - p[2] * b[1];
    n1[1] = p[2] * b[0] - p[0] * b[2];
    n1[2] = p[0] * b[1] - p[1] * b[0];
    n2[0] = p[1] * h[2] - p[2] * h[1];
    n2[1] = p[2] * h[0] - p[0] * h[2];
    n2[2] = p[0] * h[1] - p[1] * h[0];
    a_sq = 0;
    b_sq = 0;
    p_sq = 0;
    for (int i = 0; i < 3; i++) begin
      mg = (n1[i] < 0) ? -n1[i] : n1[i];
      a_sq += mg * mg;
      mg = (n2[i] < 0) ? -n2[i] : n2[i];
      b_sq += mg * mg;
      mg = (p[i] < 0) ? -p[i] : p[i];
      p_sq += mg * mg;
    end
    r.sin_phi = '0;
    r.degenerate = 1'b1;
    if (!(a_sq > {32'd0, thr} && b_sq > {32'd0, thr})) return r;
    r.degenerate = 1'b0;
    bh[0] = b[1] * h[2] - b[2] * h[1];
    bh[1] = b[2] * h[0] - b[0] * h[2];
    bh[2] = b[0] * h[1] - b[1] * h[0];
    t = p[0] * bh[0] + p[1] * bh[1] + p[2] * bh[2];
    tm = 192'((t < 0) ? -t : t);
    ab = 192'(a_sq);
    ab = ab * b_sq;
    rhs = tm * tm;
    rhs = rhs * p_sq;
    rhs = rhs << 30;
    // Largest magnitude whose lower rounding edge still fits
    s = 0;
    for (bitw = 16384; bitw != 0; bitw >>= 1) begin
      cand = s + bitw;
      if (cand <= 16384) begin
        lhs = 192'(2 * cand - 1);
        lhs = ab * (lhs * lhs);
        if (lhs <= rhs) s = cand;
      end
    end
    r.sin_phi = 16'((t < 0) ? -s : s);
    return r;
  endfunction

  // Send one item and record its expected result on transfer
  task automatic send_angles(comp_t c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_beam_x   <= c[0];
    in_beam_y   <= c[1];
    in_beam_z   <= c[2];
    in_photon_x <= c[3];
    in_photon_y <= c[4];
    in_photon_z <= c[5];
    in_hadron_x <= c[6];
    in_hadron_y <= c[7];
    in_hadron_z <= c[8];
    do @(posedge clk); while (in_stall);
    sine_queue.push_back(predict_sine(c, min_sq_shadow));
  endtask

  // Hold input idle until every expected result has come, then let the pipe settle
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (sine_queue.size() != 0) @(posedge clk);
    repeat (aps_pkg::LATENCY) @(posedge clk);
  endtask

  task automatic write_min_sq(logic [31:0] value);
    drain_pipe();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'(4 * aps_pkg::REG_MIN_NORMAL_SQ);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    min_sq_shadow = value;
  endtask

  function automatic comp_t vec9(int bx, int by, int bz, int px, int py, int pz,
                                 int hx, int hy, int hz);
    comp_t c;
    c[0] = 16'(bx); c[1] = 16'(by); c[2] = 16'(bz);
    c[3] = 16'(px); c[4] = 16'(py); c[5] = 16'(pz);
    c[6] = 16'(hx); c[7] = 16'(hy); c[8] = 16'(hz);
    return c;
  endfunction

  function automatic comp_t random_angles();
    comp_t c;
    int mode;
    int k;
    mode = $urandom_range(5);
    for (int i = 0; i < 9; i++) begin
      case (mode)
        0, 1: c[i] = 16'($urandom);
        2: c[i] = $signed(16'($urandom_range(128))) - 16'sd64;
        3: c[i] = $signed(16'($urandom_range(8))) - 16'sd4;
        4: c[i] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        default: c[i] = $signed(16'($urandom_range(8192))) - 16'sd4096;
      endcase
    end
    // Hadron as the beam shifted right by up to 3 bits: small or zero triple product
    if ($urandom_range(9) == 0) begin
      k = $urandom_range(3);
      for (int i = 0; i < 3; i++) c[6 + i] = (c[i] >>> k);
    end
    return c;
  endfunction

  task automatic test_corners();
    send_angles(vec9(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_angles(vec9(4096, 0, 0, 0, 0, 4096, 0, 4096, 0));
    send_angles(vec9(0, 4096, 0, 0, 0, 4096, 4096, 0, 0));
    send_angles(vec9(4096, 0, 0, 0, 0, 4096, 4096, 4096, 0));
    send_angles(vec9(4096, 0, 0, 0, 0, 4096, 8192, 0, 0));
    send_angles(vec9(1, 0, 0, 0, 0, 1, 0, 1, 0));
    send_angles(vec9(32767, 32767, 32767, 32767, -32768, 0, -32768, -32768, 32767));
    send_angles(vec9(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
    send_angles(vec9(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
    send_angles(vec9(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_angles(vec9(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    send_angles(vec9(3, 1, 0, 0, 0, 1, 1, 2, 0));
    send_angles(vec9(4096, 100, 0, 0, 0, 4096, -50, -4096, 0));
  endtask

  task automatic test_threshold();
    write_min_sq(32'd0);
    send_angles(vec9(1, 0, 0, 0, 0, 1, 0, 1, 0));
    send_angles(vec9(0, 0, 0, 0, 0, 1, 0, 1, 0));
    write_min_sq(32'hffff_ffff);
    send_angles(vec9(256, 0, 0, 0, 0, 256, 0, 256, 0));
    send_angles(vec9(257, 0, 0, 0, 0, 256, 0, 256, 0));
    send_angles(vec9(32767, 0, 0, 0, 0, 32767, 0, 32767, 0));
    write_min_sq(32'd4);
    send_angles(vec9(2, 0, 0, 0, 0, 1, 0, 2, 0));
    send_angles(vec9(3, 0, 0, 0, 0, 1, 0, 3, 0));
    write_min_sq(32'd1);
  endtask

  task automatic test_random_phase(int n, int idle, int stall, logic [31:0] thr);
    write_min_sq(thr);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      send_angles(random_angles());
      // Let the pipe run dry once mid-phase when the phase has no idle time
      if (i == n / 2 && idle == 0) drain_pipe();
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_beam_x   <= '0; in_beam_y   <= '0; in_beam_z   <= '0;
    in_photon_x <= '0; in_photon_y <= '0; in_photon_z <= '0;
    in_hadron_x <= '0; in_hadron_y <= '0; in_hadron_z <= '0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    min_sq_shadow = 32'd1;
    idle_pct  = 0;
    stall_pct = 0;
    fail_count = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corners();
    test_threshold();
    test_random_phase(320, 0, 0, 32'd1);
    test_random_phase(310, 74, 0, 32'd0);
    test_random_phase(310, 0, 74, 32'd1000);
    test_random_phase(310, 19, 19, $urandom);

    drain_pipe();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
